// File: rtl/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL converter.
package rgbhsl_pkg;

    // Fixed output field widths.
    localparam int HUE_W   = 15;
    localparam int LIGHT_W = 9;
    localparam int SAT_W   = 13;

    typedef logic [HUE_W-1:0]   t_hue;
    typedef logic [LIGHT_W-1:0] t_light;
    typedef logic [SAT_W-1:0]   t_sat;

    // Hue scale: one sector of 60 degrees in 1/64 degree, and the full circle.
    localparam int HUE_SECTOR = 3840;
    localparam int HUE_FULL   = 23040;

    // Saturation is Q1.12; the rounded quotient is taken with a doubled scale.
    localparam int SAT_ONE    = 4096;
    localparam int SAT_SCALE2 = 8192;

    // Quotient bits produced by each divider, one per pipeline stage.
    localparam int DIV_STEPS = 13;

    // Which component is the largest, in priority order red, green, blue.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Side information that travels next to the dividers.
    typedef struct packed {
        logic    grey;
        logic    neg;
        t_sector sector;
        t_light  light;
    } t_side;

    // Hue offset of a sector: 0, 120 or 240 degrees.
    function automatic t_hue hue_offset(input t_sector sec);
        t_hue off;
        unique case (sec)
            SEC_RED:   off = '0;
            SEC_GREEN: off = t_hue'(2 * HUE_SECTOR);
            SEC_BLUE:  off = t_hue'(4 * HUE_SECTOR);
            default:   off = '0;
        endcase
        return off;
    endfunction

endpackage

// File: rtl/rgbhsl_div_step.sv
// One restoring division step: brings in one numerator bit, yields one quotient bit.
module rgbhsl_div_step #(
    parameter int DW = 8,
    parameter int QW = 13
) (
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num_lo,
    input  logic [QW-1:0] i_quo,
    input  logic [DW-1:0] i_den,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_num_lo,
    output logic [QW-1:0] o_quo
);

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
        trial    = {i_rem, i_num_lo[QW-1]};
        diff     = trial - {1'b0, i_den};
        ge       = (trial >= {1'b0, i_den});
        o_rem    = ge ? diff[DW-1:0] : trial[DW-1:0];
        o_num_lo = {i_num_lo[QW-2:0], 1'b0};
        o_quo    = {i_quo[QW-2:0], ge};
    end

endmodule

// File: rtl/rgb_to_hsl_converter.sv
// Top level of the pipelined RGB to HSL converter.
//
// Usage: one RGB pixel word enters on the input channel (i_valid, o_stall,
// i_red_in, i_green_in, i_blue_in) and one HSL word leaves on the output
// channel (o_valid, i_stall, o_hue_out, o_lightness_out, o_saturation_out).
// A word is taken at a rising edge where valid is high and stall is low.
// Throughput is one word per clock cycle while the receiver does not
// stall. Two stages find max, min, chroma and the divider operands,
// thirteen stages each form one quotient bit of the hue and the
// saturation dividers side by side, and one stage assembles the
// result. The restoring divider, one bit per stage, sets the depth.
// Every stage has its own valid bit and moves whenever the stage after it
// is empty or moving, so bubbles close up while the receiver stalls and
// input words are still taken until all sixteen stages are full; only
// then does o_stall rise. A stalled output word holds steady.
// Reset (synchronous, active low) clears all valid bits; the pipeline is
// empty and ready in the first cycle after reset.
module rgb_to_hsl_converter #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [COMPONENT_BITS-1:0]   i_red_in,
    input  logic [COMPONENT_BITS-1:0]   i_green_in,
    input  logic [COMPONENT_BITS-1:0]   i_blue_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output rgbhsl_pkg::t_hue            o_hue_out,
    output rgbhsl_pkg::t_light          o_lightness_out,
    output rgbhsl_pkg::t_sat            o_saturation_out
);

    localparam int CB    = COMPONENT_BITS;
    localparam int NDIV  = rgbhsl_pkg::DIV_STEPS;
    // Stage 0: max/min; stage 1: operands; stages 2..NDIV+1: divide; last: output.
    localparam int LAST  = NDIV + 2;
    localparam int HN_W  = CB + NDIV;       // hue numerator width
    localparam int SD_W  = CB + 1;          // saturation divisor width
    localparam int SN_W  = SD_W + NDIV;     // saturation numerator width
    localparam logic [CB-1:0] FULL = '1;

    // Handshake: adv[k] says stage k loads this cycle.
    logic [0:LAST+1] adv;
    logic [0:LAST]   r_vld;

    always_comb begin
        adv[LAST+1] = !i_stall;
        for (int k = LAST; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: find the largest component (red wins ties, then green), the
    // chroma and the sum, and pick the two components that give the hue
    // difference for that sector.
    rgbhsl_pkg::t_sector n0_sector;
    logic [CB-1:0]       n0_mx, n0_mn, n0_a, n0_b;
    rgbhsl_pkg::t_sector r0_sector;
    logic [CB-1:0]       r0_chroma, r0_a, r0_b;
    logic [CB:0]         r0_sum;

    always_comb begin
        n0_mn = i_red_in;
        if (i_green_in < n0_mn) begin
            n0_mn = i_green_in;
        end
        if (i_blue_in < n0_mn) begin
            n0_mn = i_blue_in;
        end
        if (i_red_in >= i_green_in && i_red_in >= i_blue_in) begin
            n0_sector = rgbhsl_pkg::SEC_RED;
            n0_mx     = i_red_in;
            n0_a      = i_green_in;
            n0_b      = i_blue_in;
        end else if (i_green_in >= i_blue_in) begin
            n0_sector = rgbhsl_pkg::SEC_GREEN;
            n0_mx     = i_green_in;
            n0_a      = i_blue_in;
            n0_b      = i_red_in;
        end else begin
            n0_sector = rgbhsl_pkg::SEC_BLUE;
            n0_mx     = i_blue_in;
            n0_a      = i_red_in;
            n0_b      = i_green_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_sector <= n0_sector;
            r0_chroma <= n0_mx - n0_mn;
            r0_sum    <= {1'b0, n0_mx} + {1'b0, n0_mn};
            r0_a      <= n0_a;
            r0_b      <= n0_b;
        end
    end

    // Divider pipeline state, indexed by stage 1 through NDIV+1.
    logic [CB-1:0]      r_hrem [1:NDIV+1];
    logic [NDIV-1:0]    r_hlo  [1:NDIV+1];
    logic [NDIV-1:0]    r_hquo [1:NDIV+1];
    logic [CB-1:0]      r_hden [1:NDIV+1];
    logic [SD_W-1:0]    r_srem [1:NDIV+1];
    logic [NDIV-1:0]    r_slo  [1:NDIV+1];
    logic [NDIV-1:0]    r_squo [1:NDIV+1];
    logic [SD_W-1:0]    r_sden [1:NDIV+1];
    rgbhsl_pkg::t_side  r_side [1:NDIV+1];

    // Stage 1: signed hue difference and the two numerators. A negative
    // difference needs the ceiling of its magnitude, so chroma-1 is added
    // before the floor division. The saturation quotient is rounded with
    // ties upward by dividing 2*4096*chroma + den by 2*den.
    logic            n1_neg;
    logic [CB-1:0]   n1_diff;
    logic [CB-1:0]   n1_den;
    logic [HN_W-1:0] n1_hnum;
    logic [SN_W-1:0] n1_snum;
    rgbhsl_pkg::t_side n1_side;

    always_comb begin
        n1_neg  = (r0_a < r0_b);
        n1_diff = n1_neg ? (r0_b - r0_a) : (r0_a - r0_b);
        if (r0_sum <= {1'b0, FULL}) begin
            n1_den = r0_sum[CB-1:0];
        end else begin
            n1_den = CB'({FULL, 1'b0} - r0_sum);
        end
        n1_hnum = HN_W'(n1_diff) * HN_W'(rgbhsl_pkg::HUE_SECTOR)
                + (n1_neg ? (HN_W'(r0_chroma) - HN_W'(1)) : '0);
        n1_snum = SN_W'(r0_chroma) * SN_W'(rgbhsl_pkg::SAT_SCALE2) + SN_W'(n1_den);
        n1_side.grey   = (r0_chroma == '0);
        n1_side.neg    = n1_neg;
        n1_side.sector = r0_sector;
        n1_side.light  = rgbhsl_pkg::t_light'(r0_sum);
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_hrem[1] <= n1_hnum[HN_W-1:NDIV];
            r_hlo[1]  <= n1_hnum[NDIV-1:0];
            r_hquo[1] <= '0;
            r_hden[1] <= r0_chroma;
            r_srem[1] <= n1_snum[SN_W-1:NDIV];
            r_slo[1]  <= n1_snum[NDIV-1:0];
            r_squo[1] <= '0;
            r_sden[1] <= {n1_den, 1'b0};
            r_side[1] <= n1_side;
        end
    end

    // Stages 2..NDIV+1: one quotient bit of each divider per stage.
    for (genvar k = 2; k <= NDIV + 1; k++) begin : g_div
        logic [CB-1:0]   h_rem;
        logic [NDIV-1:0] h_lo, h_quo;
        logic [SD_W-1:0] s_rem;
        logic [NDIV-1:0] s_lo, s_quo;

        rgbhsl_div_step #(.DW(CB), .QW(NDIV)) u_hue_step (
            .i_rem    (r_hrem[k-1]),
            .i_num_lo (r_hlo[k-1]),
            .i_quo    (r_hquo[k-1]),
            .i_den    (r_hden[k-1]),
            .o_rem    (h_rem),
            .o_num_lo (h_lo),
            .o_quo    (h_quo)
        );

        rgbhsl_div_step #(.DW(SD_W), .QW(NDIV)) u_sat_step (
            .i_rem    (r_srem[k-1]),
            .i_num_lo (r_slo[k-1]),
            .i_quo    (r_squo[k-1]),
            .i_den    (r_sden[k-1]),
            .o_rem    (s_rem),
            .o_num_lo (s_lo),
            .o_quo    (s_quo)
        );

        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_hrem[k] <= h_rem;
                r_hlo[k]  <= h_lo;
                r_hquo[k] <= h_quo;
                r_hden[k] <= r_hden[k-1];
                r_srem[k] <= s_rem;
                r_slo[k]  <= s_lo;
                r_squo[k] <= s_quo;
                r_sden[k] <= r_sden[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Last stage: add or subtract the hue quotient to the sector offset and
    // wrap a negative hue by one full circle. Grey pixels force hue and
    // saturation to zero; the saturation quotient never exceeds one, but it
    // is clamped all the same.
    rgbhsl_pkg::t_side n_side;
    logic [15:0]       n_off, n_hq, n_hue16;
    rgbhsl_pkg::t_hue  n_hue;
    rgbhsl_pkg::t_sat  n_sat;
    rgbhsl_pkg::t_hue  r_hue;
    rgbhsl_pkg::t_light r_light;
    rgbhsl_pkg::t_sat  r_sat;

    always_comb begin
        n_side = r_side[NDIV+1];
        n_off  = 16'(rgbhsl_pkg::hue_offset(n_side.sector));
        n_hq   = 16'(r_hquo[NDIV+1]);
        if (!n_side.neg) begin
            n_hue16 = n_off + n_hq;
        end else if (n_off >= n_hq) begin
            n_hue16 = n_off - n_hq;
        end else begin
            n_hue16 = n_off + 16'(rgbhsl_pkg::HUE_FULL) - n_hq;
        end
        if (r_squo[NDIV+1] > rgbhsl_pkg::t_sat'(rgbhsl_pkg::SAT_ONE)) begin
            n_sat = rgbhsl_pkg::t_sat'(rgbhsl_pkg::SAT_ONE);
        end else begin
            n_sat = rgbhsl_pkg::t_sat'(r_squo[NDIV+1]);
        end
        n_hue = rgbhsl_pkg::t_hue'(n_hue16);
        if (n_side.grey) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST]) begin
            r_hue   <= n_hue;
            r_light <= n_side.light;
            r_sat   <= n_sat;
        end
    end

    assign o_valid          = r_vld[LAST];
    assign o_hue_out        = r_hue;
    assign o_lightness_out  = r_light;
    assign o_saturation_out = r_sat;

endmodule

// File: rtl/rgbhsl_checker.sv
// Port-level checks for the RGB to HSL converter, bound to its top level.
module rgbhsl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input rgbhsl_pkg::t_hue   o_hue_out,
    input rgbhsl_pkg::t_light o_lightness_out,
    input rgbhsl_pkg::t_sat   o_saturation_out
);

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    // Input backs up only while a valid output word is held; the design stalls only with every stage full.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output is not blocked");

    // Results stay within the hue circle and saturation of one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_out < rgbhsl_pkg::t_hue'(rgbhsl_pkg::HUE_FULL)
                     && o_saturation_out <= rgbhsl_pkg::t_sat'(rgbhsl_pkg::SAT_ONE)))
        else $error("hue or saturation out of range");

    // A stalled output word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hue_out)
            && $stable(o_lightness_out) && $stable(o_saturation_out)))
        else $error("stalled output word changed");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_hue_out        (o_hue_out),
    .o_lightness_out  (o_lightness_out),
    .o_saturation_out (o_saturation_out)
);
